[rtl/core/lpm_pkg.sv]
// Shared types and constants for the latency percentile monitor.
// No dependencies; imported by the core.
package lpm_pkg;
    localparam int WINDOW_DEF = 256;
    localparam int SAMPLE_W   = 32;
    localparam int OP_W       = 2;
    localparam int OUT_W      = 296;

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CAND  = 7'b0000010,
        ST_CWAIT = 7'b0000100,
        ST_SWEEP = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_OUT   = 7'b1000000
    } lpm_state_t;
endpackage

[rtl/core/lpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/latency_percentile_monitor_core.sv]
// Latency percentile monitor core: records samples, answers queries, clears.
// Depends on lpm_pkg and lpm_ram.
//
// Record and clear requests complete in the idle state. For a query, a single
// compare unit walks every stored sample as a candidate and, per candidate,
// sweeps the whole window through the RAM read port counting smaller and equal
// samples to find its sorted rank; the 50th, 95th and 99th percentiles are
// settled in the same passes. An empty query skips the sweeps and answers with
// no_data set. s_tready is low while a query is in progress or its result
// cannot yet be loaded.
module latency_percentile_monitor_core #(
    parameter int WINDOW = lpm_pkg::WINDOW_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lpm_pkg::SAMPLE_W-1:0] s_tdata,  // [31:0] latency_value
    input  logic [lpm_pkg::OP_W-1:0]     s_tuser,  // [1:0] operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] no_data, [64:1] total_count, [128:65] total_sum, [160:129] minimum,
    // [192:161] maximum, [224:193] median, [256:225] pct95, [288:257] pct99
    output logic [lpm_pkg::OUT_W-1:0]    m_tdata
);
    import lpm_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = AW + 1;
    localparam int CW = FW + 7;
    localparam logic [FW-1:0] WIN_F = FW'(WINDOW);

    lpm_state_t state_reg, state_next;
    logic [63:0] count_reg, count_next, sum_reg, sum_next;
    logic [SAMPLE_W-1:0] min_reg, min_next, max_reg, max_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [FW-1:0] cidx_reg, cidx_next, sidx_reg, sidx_next;
    logic [FW-1:0] less_reg, less_next, leq_reg, leq_next;
    logic pend_reg;
    logic [SAMPLE_W-1:0] cand_reg, cand_next;
    logic [SAMPLE_W-1:0] p50_reg, p50_next, p95_reg, p95_next, p99_reg, p99_next;
    logic [CW-1:0] nk50_reg, nk50_next, nk95_reg, nk95_next, nk99_reg, nk99_next;
    logic empty_reg, empty_next;
    logic mv_reg, mv_next;
    logic [OUT_W-1:0] mdata_reg, mdata_next;

    logic in_fire, we;
    logic [AW-1:0] waddr, raddr;
    logic [SAMPLE_W-1:0] rdata;
    logic [CW-1:0] less_k, leq_k;
    logic out_free;

    lpm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign out_free = !mv_reg || m_tready;
    assign we       = in_fire && (s_tuser == OP_RECORD);
    assign waddr    = (fill_reg < WIN_F) ? fill_reg[AW-1:0] : oldest_reg;
    assign raddr    = (state_reg == ST_CAND) ? cidx_reg[AW-1:0] : sidx_reg[AW-1:0];
    assign less_k   = CW'(less_reg) * CW'(100);
    assign leq_k    = CW'(leq_reg) * CW'(100);

    // sequencer and datapath
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        cidx_next   = cidx_reg;
        sidx_next   = sidx_reg;
        less_next   = less_reg;
        leq_next    = leq_reg;
        cand_next   = cand_reg;
        p50_next    = p50_reg;
        p95_next    = p95_reg;
        p99_next    = p99_reg;
        nk50_next   = nk50_reg;
        nk95_next   = nk95_reg;
        nk99_next   = nk99_reg;
        empty_next  = empty_reg;
        mv_next     = mv_reg && !m_tready;
        mdata_next  = mdata_reg;

        // count samples against the candidate as read data returns
        if (pend_reg)
        begin
            if (rdata < cand_reg)
            begin
                less_next = less_reg + FW'(1);
            end
            if (rdata <= cand_reg)
            begin
                leq_next = leq_reg + FW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        OP_RECORD:
                        begin
                            count_next = count_reg + 64'd1;
                            sum_next   = sum_reg + 64'(s_tdata);
                            if (s_tdata < min_reg) min_next = s_tdata;
                            if (s_tdata > max_reg) max_next = s_tdata;
                            if (fill_reg < WIN_F)
                            begin
                                fill_next = fill_reg + FW'(1);
                            end
                            else
                            begin
                                oldest_next = (oldest_reg == AW'(WINDOW - 1)) ?
                                              '0 : oldest_reg + AW'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            sum_next    = '0;
                            min_next    = '1;
                            max_next    = '0;
                            fill_next   = '0;
                            oldest_next = '0;
                        end
                        OP_QUERY:
                        begin
                            empty_next = (fill_reg == '0);
                            nk50_next  = CW'(fill_reg) * CW'(50);
                            nk95_next  = CW'(fill_reg) * CW'(95);
                            nk99_next  = CW'(fill_reg) * CW'(99);
                            cidx_next  = '0;
                            state_next = (fill_reg == '0) ? ST_OUT : ST_CAND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CAND:
            begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                cand_next  = rdata;
                sidx_next  = '0;
                less_next  = '0;
                leq_next   = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                sidx_next = sidx_reg + FW'(1);
                if (sidx_reg == fill_reg - FW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // rank window of this candidate covers the target index
                if (less_k <= nk50_reg && nk50_reg < leq_k) p50_next = cand_reg;
                if (less_k <= nk95_reg && nk95_reg < leq_k) p95_next = cand_reg;
                if (less_k <= nk99_reg && nk99_reg < leq_k) p99_next = cand_reg;
                cidx_next = cidx_reg + FW'(1);
                state_next = (cidx_reg == fill_reg - FW'(1)) ? ST_OUT : ST_CAND;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    mv_next = 1'b1;
                    if (empty_reg)
                    begin
                        mdata_next = OUT_W'(1);
                    end
                    else
                    begin
                        mdata_next = OUT_W'({p99_reg, p95_reg, p50_reg, max_reg,
                                             min_reg, sum_reg, count_reg, 1'b0});
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            sum_reg    <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            fill_reg   <= '0;
            oldest_reg <= '0;
            pend_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            pend_reg   <= (state_reg == ST_SWEEP);
            mv_reg     <= mv_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        cidx_reg  <= cidx_next;
        sidx_reg  <= sidx_next;
        less_reg  <= less_next;
        leq_reg   <= leq_next;
        cand_reg  <= cand_next;
        p50_reg   <= p50_next;
        p95_reg   <= p95_next;
        p99_reg   <= p99_next;
        nk50_reg  <= nk50_next;
        nk95_reg  <= nk95_next;
        nk99_reg  <= nk99_next;
        empty_reg <= empty_next;
        mdata_reg <= mdata_next;
    end
endmodule
